[sv/qstp_pkg.sv]
package qstp_pkg;

  // Queue and tone table dimensions
  localparam int unsigned QUEUE_DEPTH       = 6;
  localparam int unsigned SEGMENTS_PER_TONE = 3;
  localparam int unsigned TONE_KINDS        = 6;
  localparam int unsigned ROM_SEGS          = 3;

  // Audio timing
  localparam int unsigned RATE_HZ   = 16000;
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned AMP_RESET = 5000;

  // Field and state widths
  localparam int unsigned TONE_W   = 8;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned PHASE_W  = 7;
  localparam int unsigned LEFT_W   = 11;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ROMSEG_W = 2;
  localparam int unsigned QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SEG_W    = (SEGMENTS_PER_TONE > 1) ? $clog2(SEGMENTS_PER_TONE) : 1;

  // Register port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = '0;

  // Item function codes
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // Segment table: a 0 entry marks an empty segment (period 1, no samples)
  localparam bit SEG_ON [TONE_KINDS][ROM_SEGS] = '{
    '{1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0}
  };

  // Samples per square period, 16000 / hz
  localparam int unsigned SEG_PERIOD [TONE_KINDS][ROM_SEGS] = '{
    '{RATE_HZ / 440, 1, 1},
    '{RATE_HZ / 880, 1, 1},
    '{RATE_HZ / 587, RATE_HZ / 880, 1},
    '{RATE_HZ / 660, RATE_HZ / 880, 1},
    '{RATE_HZ / 220, 1, 1},
    '{RATE_HZ / 180, 1, 1}
  };

  // Samples per segment, 16000 * ms / 1000
  localparam int unsigned SEG_LEN [TONE_KINDS][ROM_SEGS] = '{
    '{RATE_HZ * 80 / MS_PER_S, 0, 0},
    '{RATE_HZ * 60 / MS_PER_S, 0, 0},
    '{RATE_HZ * 75 / MS_PER_S, RATE_HZ * 75 / MS_PER_S, 0},
    '{RATE_HZ * 100 / MS_PER_S, RATE_HZ * 100 / MS_PER_S, 0},
    '{RATE_HZ * 120 / MS_PER_S, 0, 0},
    '{RATE_HZ * 100 / MS_PER_S, 0, 0}
  };

  typedef struct packed {
    logic              func;
    logic [TONE_W-1:0] tone;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       tone_last;
    logic                       request_accepted;
    logic [LEVEL_W-1:0]         queue_level;
  } out_item_t;

  // Queue control from the top level
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TONE_W-1:0] tone;
  } fifo_ctl_t;

  // Queue status toward the player
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [TONE_W-1:0] head_tone;
  } fifo_stat_t;

  // Player result for one tick
  typedef struct packed {
    logic                       pop;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       tone_last;
  } play_out_t;

  typedef struct packed {
    logic               present;
    logic [PHASE_W-1:0] period;
    logic [LEFT_W-1:0]  length;
  } seg_info_t;

  // Segment lookup; anything outside the table reads as absent
  function automatic seg_info_t seg_lookup(logic [KIND_W-1:0] kind, logic [SEG_W:0] seg);
    seg_info_t r;
    r.present = 1'b0;
    r.period  = PHASE_W'(1);
    r.length  = '0;
    if (kind < TONE_KINDS && seg < SEGMENTS_PER_TONE && seg < ROM_SEGS) begin
      r.present = SEG_ON[kind][seg[ROMSEG_W-1:0]];
      r.period  = PHASE_W'(SEG_PERIOD[kind][seg[ROMSEG_W-1:0]]);
      r.length  = LEFT_W'(SEG_LEN[kind][seg[ROMSEG_W-1:0]]);
    end
    return r;
  endfunction

endpackage

[sv/queued_square_tone_player_unit.sv]
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the single output register is the only stage, and a
// new item is taken whenever that register is empty or being drained in the same cycle.
// Reset (synchronous, active high): queue empty, player idle, output empty,
// amplitude 5000. Queue storage is not cleared; entries are read only once filled.
module queued_square_tone_player_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qstp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qstp_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qstp_pkg::PADDR_W-1:0]  paddr,
  input  logic [qstp_pkg::PDATA_W-1:0]  pwdata,
  output logic [qstp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import qstp_pkg::*;

  logic              accept;
  logic              tick;
  logic [AMP_W-1:0]  amplitude;
  fifo_ctl_t         fifo_ctl;
  fifo_stat_t        fifo_stat;
  logic [QCNT_W-1:0] count_next;
  play_out_t         play;
  out_item_t         result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (in_data.func == FUNC_TICK);

  qstp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .amplitude (amplitude)
  );

  // Requests are refused when the queue is full
  assign fifo_ctl.push = accept && (in_data.func == FUNC_REQUEST) && !fifo_stat.full;
  assign fifo_ctl.pop  = play.pop;
  assign fifo_ctl.tone = in_data.tone;

  qstp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .ctl        (fifo_ctl),
    .stat       (fifo_stat),
    .count_next (count_next)
  );

  qstp_player u_player (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .stat      (fifo_stat),
    .amplitude (amplitude),
    .result    (play)
  );

  // Result assembly
  always_comb begin
    result.sample           = play.sample;
    result.sample_valid     = play.sample_valid;
    result.tone_last        = play.tone_last;
    result.request_accepted = fifo_ctl.push;
    result.queue_level      = LEVEL_W'(count_next);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

[sv/qstp_regs.sv]
module qstp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qstp_pkg::PADDR_W-1:0]  paddr,
  input  logic [qstp_pkg::PDATA_W-1:0]  pwdata,
  output logic [qstp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [qstp_pkg::AMP_W-1:0]    amplitude
);
  import qstp_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Amplitude register
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_W'(AMP_RESET);
    end else if (wr_en && reg_idx == REG_AMPLITUDE) begin
      amplitude <= pwdata[AMP_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_AMPLITUDE) begin
      prdata = PDATA_W'(amplitude);
    end
  end

endmodule

[sv/qstp_fifo.sv]
module qstp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  qstp_pkg::fifo_ctl_t          ctl,
  output qstp_pkg::fifo_stat_t         stat,
  output logic [qstp_pkg::QCNT_W-1:0]  count_next
);
  import qstp_pkg::*;

  logic [TONE_W-1:0] mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head;
  logic [QIDX_W-1:0] head_next;
  logic [QCNT_W-1:0] count;
  logic [QIDX_W:0]   tail_sum;
  logic [QIDX_W-1:0] tail;

  // Tail wraps at most once since count never exceeds the depth
  assign tail_sum = (QIDX_W+1)'(head) + (QIDX_W+1)'(count);
  assign tail     = (tail_sum >= (QIDX_W+1)'(QUEUE_DEPTH))
                    ? QIDX_W'(tail_sum - (QIDX_W+1)'(QUEUE_DEPTH))
                    : QIDX_W'(tail_sum);

  assign stat.full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.head_tone = mem[head];

  // Pointer and fill-level update
  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
      head_next  = (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.tone;
    end
  end

endmodule

[sv/qstp_player.sv]
module qstp_player (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  qstp_pkg::fifo_stat_t        stat,
  input  logic [qstp_pkg::AMP_W-1:0]  amplitude,
  output qstp_pkg::play_out_t         result
);
  import qstp_pkg::*;

  logic               playing;
  logic               playing_next;
  logic [KIND_W-1:0]  current_tone;
  logic [KIND_W-1:0]  current_tone_next;
  logic [SEG_W-1:0]   segment_index;
  logic [SEG_W-1:0]   segment_index_next;
  logic [PHASE_W-1:0] phase_count;
  logic [PHASE_W-1:0] phase_count_next;
  logic [LEFT_W-1:0]  samples_left;
  logic [LEFT_W-1:0]  samples_left_next;

  logic               emit;
  logic [SEG_W:0]     seg_nxt;
  logic [PHASE_W:0]   phase_inc;
  seg_info_t          info_first;
  seg_info_t          info_cur;
  seg_info_t          info_nxt;
  logic [SAMPLE_W-1:0] amp_ext;

  assign amp_ext = SAMPLE_W'(amplitude);

  // Dequeue, square-wave level and segment advance for one tick
  always_comb begin
    playing_next       = playing;
    current_tone_next  = current_tone;
    segment_index_next = segment_index;
    phase_count_next   = phase_count;
    samples_left_next  = samples_left;
    emit               = playing;
    seg_nxt            = '0;
    phase_inc          = '0;
    info_first         = '0;
    info_cur           = '0;
    info_nxt           = '0;
    result             = '0;

    if (tick) begin
      // idle: start the next queued tone, dropping unknown tone numbers
      if (!playing && !stat.empty) begin
        result.pop = 1'b1;
        if (stat.head_tone < TONE_W'(TONE_KINDS)) begin
          current_tone_next = KIND_W'(stat.head_tone);
          info_first = seg_lookup(current_tone_next, '0);
          if (info_first.present) begin
            segment_index_next = '0;
            phase_count_next   = '0;
            samples_left_next  = info_first.length;
            emit               = (info_first.length != '0);
            playing_next       = emit;
          end
        end
      end

      if (emit) begin
        info_cur = seg_lookup(current_tone_next, (SEG_W+1)'(segment_index_next));
        if (!info_cur.present) begin
          info_cur.period = PHASE_W'(1);
        end
        result.sample_valid = 1'b1;
        result.sample = (phase_count_next < (info_cur.period >> 1))
                        ? amp_ext : (~amp_ext + 1'b1);

        phase_inc = (PHASE_W+1)'(phase_count_next) + 1'b1;
        phase_count_next = (phase_inc >= (PHASE_W+1)'(info_cur.period))
                           ? '0 : PHASE_W'(phase_inc);
        if (samples_left_next != '0) begin
          samples_left_next = samples_left_next - 1'b1;
        end

        // segment done: chain into the next one or end the tone
        if (samples_left_next == '0) begin
          seg_nxt  = (SEG_W+1)'(segment_index_next) + 1'b1;
          info_nxt = seg_lookup(current_tone_next, seg_nxt);
          if (info_nxt.present) begin
            segment_index_next = SEG_W'(seg_nxt);
            phase_count_next   = '0;
            samples_left_next  = info_nxt.length;
          end
          if (!info_nxt.present || info_nxt.length == '0) begin
            playing_next     = 1'b0;
            result.tone_last = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      current_tone  <= '0;
      segment_index <= '0;
      phase_count   <= '0;
      samples_left  <= '0;
    end else begin
      playing       <= playing_next;
      current_tone  <= current_tone_next;
      segment_index <= segment_index_next;
      phase_count   <= phase_count_next;
      samples_left  <= samples_left_next;
    end
  end

endmodule

[sv/qstp_checker.sv]
module qstp_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input qstp_pkg::out_item_t out_data
);
  import qstp_pkg::*;

  // Output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // A tick result never reports a queued request
  a_tick_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sample_valid |-> !out_data.request_accepted)
    else $error("sample and request acceptance in one result");

  // No sample means silence and no tone end
  a_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.sample_valid |-> out_data.sample == '0 && !out_data.tone_last)
    else $error("silent result carries sample data");

  // Queue level stays within depth
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.queue_level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

endmodule

bind queued_square_tone_player_unit qstp_checker u_qstp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/qstp_tone_checker.sv]
`timescale 1ns / 1ps

module qstp_tone_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  qstp_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  qstp_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qstp_pkg::PADDR_W-1:0]  paddr,
  input  logic [qstp_pkg::PDATA_W-1:0]  pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            pending
);
  import qstp_pkg::*;

  localparam logic [PADDR_W-1:0] AMP_ADDR = {REG_AMPLITUDE, 2'b00};

  // Tone table: {hz, ms} per segment, hz of zero ends the tone
  localparam int unsigned TONE_HZ [TONE_KINDS][ROM_SEGS] = '{
    '{440, 0, 0}, '{880, 0, 0}, '{587, 880, 0},
    '{660, 880, 0}, '{220, 0, 0}, '{180, 0, 0}
  };
  localparam int unsigned TONE_MS [TONE_KINDS][ROM_SEGS] = '{
    '{80, 0, 0}, '{60, 0, 0}, '{75, 75, 0},
    '{100, 100, 0}, '{120, 0, 0}, '{100, 0, 0}
  };

  // Shadow of the player state
  logic [AMP_W-1:0]    amp;
  logic [TONE_W-1:0]   tone_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0]   q_head;
  logic [QCNT_W-1:0]   q_count;
  bit                  playing;
  logic [KIND_W-1:0]   cur_tone;
  logic [ROMSEG_W-1:0] seg_idx;
  logic [PHASE_W-1:0]  phase;
  logic [LEFT_W-1:0]   seg_left;

  out_item_t awaited_items [$];
  int        result_no;

  function automatic bit seg_present(int unsigned seg);
    return (cur_tone < TONE_KINDS) && (seg < SEGMENTS_PER_TONE) && (seg < ROM_SEGS) &&
           (TONE_HZ[cur_tone][seg] != 0);
  endfunction

  function automatic void start_segment(int unsigned seg);
    seg_idx  = ROMSEG_W'(seg);
    phase    = '0;
    seg_left = LEFT_W'(RATE_HZ * TONE_MS[cur_tone][seg] / MS_PER_S);
  endfunction

  // One tick or request; returns the result it should produce
  function automatic out_item_t tone_step(in_item_t item);
    out_item_t         r;
    logic [TONE_W-1:0] t;
    int unsigned       tail;
    int unsigned       period;
    int unsigned       nxt;
    bit                emit;
    r = '0;
    if (item.func == FUNC_REQUEST) begin
      if (q_count < QUEUE_DEPTH) begin
        tail = (q_head + q_count) % QUEUE_DEPTH;
        tone_q[tail] = item.tone;
        q_count = q_count + 1'b1;
        r.request_accepted = 1'b1;
      end
    end else begin
      emit = playing;
      // idle: pull the next tone, bad numbers are thrown away
      if (!playing && q_count > 0) begin
        t = tone_q[q_head];
        q_head = (q_head == QUEUE_DEPTH - 1) ? '0 : q_head + 1'b1;
        q_count = q_count - 1'b1;
        if (t < TONE_KINDS) begin
          cur_tone = KIND_W'(t);
          if (seg_present(0)) begin
            start_segment(0);
            playing = 1'b1;
            emit = (seg_left > 0);
            if (!emit) playing = 1'b0;
          end
        end
      end
      if (emit) begin
        period = RATE_HZ / TONE_HZ[cur_tone][seg_idx];
        if (phase < period / 2) r.sample = $signed({1'b0, amp});
        else                    r.sample = -$signed({1'b0, amp});
        r.sample_valid = 1'b1;
        phase = phase + 1'b1;
        if (phase >= period) phase = '0;
        if (seg_left > 0) seg_left = seg_left - 1'b1;
        // segment done: chain the next one or end the tone
        if (seg_left == 0) begin
          nxt = seg_idx + 1;
          if (seg_present(nxt)) start_segment(nxt);
          if (!seg_present(nxt) || seg_left == 0) begin
            playing     = 1'b0;
            r.tone_last = 1'b1;
          end
        end
      end
    end
    r.queue_level = LEVEL_W'(q_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      amp      = AMP_W'(AMP_RESET);
      q_head   = '0;
      q_count  = '0;
      playing  = 1'b0;
      cur_tone = '0;
      seg_idx  = '0;
      phase    = '0;
      seg_left = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) tone_q[i] = '0;
      awaited_items.delete();
      mismatches = 0;
      result_no  = 0;
    end else begin
      // register write on the access cycle
      if (psel && penable && pwrite && pready && paddr == AMP_ADDR)
        amp = pwdata[AMP_W-1:0];

      // output transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_items.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing awaited: sample %0d valid %0b last %0b",
                     result_no, out_data.sample, out_data.sample_valid, out_data.tone_last);
        end else begin
          want = awaited_items.pop_front();
          if (out_data.sample !== want.sample || out_data.sample_valid !== want.sample_valid ||
              out_data.tone_last !== want.tone_last ||
              out_data.request_accepted !== want.request_accepted ||
              out_data.queue_level !== want.queue_level) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected sample %0d valid %0b last %0b acc %0b level %0d,",
                        " got sample %0d valid %0b last %0b acc %0b level %0d"},
                       result_no, want.sample, want.sample_valid, want.tone_last,
                       want.request_accepted, want.queue_level,
                       out_data.sample, out_data.sample_valid, out_data.tone_last,
                       out_data.request_accepted, out_data.queue_level);
          end
        end
        result_no++;
      end

      // input transaction
      if (in_valid && in_ready) awaited_items.push_back(tone_step(in_data));
    end
    pending <= awaited_items.size();
  end

endmodule

[verif/queued_square_tone_player_unit_tb.sv]
`timescale 1ns / 1ps

module queued_square_tone_player_unit_tb;
  import qstp_pkg::*;

  localparam logic [PADDR_W-1:0] AMP_ADDR      = {REG_AMPLITUDE, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 175;

  typedef enum {RX_FREE, RX_MOSTLY, RX_HALF, RX_PERIODIC} rx_mode_e;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int pending;
  int hold_seq;
  int burst_left;
  int gap_max;

  always #10 clk = ~clk;

  queued_square_tone_player_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  qstp_tone_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Mostly valid tones, some out of range
  function automatic logic [TONE_W-1:0] pick_tone();
    case ($urandom_range(0, 9))
      0:       return TONE_W'($urandom_range(TONE_KINDS, 255));
      1:       return TONE_W'($urandom_range(0, 255));
      default: return TONE_W'($urandom_range(0, TONE_KINDS - 1));
    endcase
  endfunction

  // Offer one transaction, bursts separated by random gaps
  task automatic offer(input logic func, input logic [TONE_W-1:0] tone);
    int       gap;
    in_item_t item;
    item.func = func;
    item.tone = tone;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every awaited result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: changing ready patterns, plus long hold-offs on request
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       on_len;
    int       off_len;
    int       cyc;
    int       hold_seen;
    bit       rdy;
    out_ready <= 1'b0;
    span      = 0;
    cyc       = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span <= 0) begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        span    = $urandom_range(32, 400);
        on_len  = $urandom_range(1, 6);
        off_len = $urandom_range(1, 6);
        cyc     = 0;
      end
      span--;
      case (mode)
        RX_FREE:     rdy = 1'b1;
        RX_MOSTLY:   rdy = ($urandom_range(0, 3) != 0);
        RX_HALF:     rdy = 1'($urandom_range(0, 1));
        RX_PERIODIC: rdy = ((cyc % (on_len + off_len)) < on_len);
        default:     rdy = 1'b1;
      endcase
      cyc++;
      out_ready <= rdy;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [AMP_W-1:0] amp_levels [6];
    int               phase_items;
    int               n_req;
    int               n_tick;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_data    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    hold_seq   <= 0;
    burst_left = 0;
    gap_max    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write to an unmapped address must leave the amplitude alone
    apb_write(UNMAPPED_ADDR, '1);

    // directed: idle ticks, fill to full, refused requests, bad tones
    offer(FUNC_TICK, 8'h00);
    offer(FUNC_TICK, 8'hFF);
    hold_seq <= hold_seq + 1;
    offer(FUNC_REQUEST, 8'hFF);
    offer(FUNC_REQUEST, TONE_W'(TONE_KINDS));
    offer(FUNC_REQUEST, 8'd1);
    offer(FUNC_REQUEST, 8'd0);
    offer(FUNC_REQUEST, 8'd5);
    offer(FUNC_REQUEST, 8'd2);
    offer(FUNC_REQUEST, 8'd3);
    offer(FUNC_REQUEST, 8'h80);
    offer(FUNC_TICK, 8'h00);
    offer(FUNC_TICK, 8'hFF);
    offer(FUNC_TICK, 8'h55);
    offer(FUNC_TICK, 8'hAA);
    offer(FUNC_TICK, 8'h00);
    offer(FUNC_REQUEST, 8'd4);
    offer(FUNC_REQUEST, 8'h7F);
    offer(FUNC_TICK, 8'hFF);

    // random phases, one amplitude each; mostly ticks so tones run to their end
    amp_levels = '{15'd0, 15'd32767, 15'd1, 15'd32766, 15'd0, 15'd5000};
    amp_levels[4] = AMP_W'($urandom_range(2, 32765));
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      apb_write(AMP_ADDR, PDATA_W'(amp_levels[ph]));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (phase_items == 0 || $urandom_range(0, 7) == 0) hold_seq <= hold_seq + 1;
        n_req = $urandom_range(1, 2);
        repeat (n_req) offer(FUNC_REQUEST, pick_tone());
        n_tick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(40, 120);
        if (phase_items + n_req + n_tick > PHASE_ITEMS)
          n_tick = (PHASE_ITEMS > phase_items + n_req) ? PHASE_ITEMS - phase_items - n_req : 0;
        repeat (n_tick) begin
          if ($urandom_range(0, 49) == 0) offer(FUNC_REQUEST, pick_tone());
          else                            offer(FUNC_TICK, TONE_W'($urandom));
        end
        phase_items += n_req + n_tick;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("queued_square_tone_player_unit test passed");
    end else begin
      $display("queued_square_tone_player_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25ms;
    $display("queued_square_tone_player_unit test failed");
    $finish;
  end

endmodule
